// ===== src/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants for the moving-average window filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Window-size register
  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd16;

  // Quotient bits resolved per divider cycle
  localparam int DIV_DIGITS = 4;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } mavg_state_t;

endpackage

// ===== src/mavg_ring.sv =====
// ----------------------------------------------------------------------------
// mavg_ring
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mavg_ring #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mavg_div.sv =====
// ----------------------------------------------------------------------------
// mavg_div
// Iterative signed-by-unsigned divider, truncating toward zero. Restoring
// division on the magnitude, DIV_DIGITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module mavg_div #(
  parameter int SUM_W = 32,
  parameter int DEN_W = 9,
  parameter int QUO_W = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic signed [QUO_W-1:0] quotient
);
  import mavg_pkg::*;

  localparam int ITER  = (SUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DIV_W = ITER * DIV_DIGITS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [DIV_W-1:0] dvd;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic [SUM_W-1:0] mag;
  logic [DIV_W-1:0] dvd_next;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W:0]   trial;
  logic [QUO_W-1:0] q_mag;

  // magnitude of the dividend
  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  // one iteration of restoring division (DIV_DIGITS quotient bits)
  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      trial    = {rem_next, dvd_next[DIV_W-1]};
      dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial       = trial - {1'b0, den};
        dvd_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DIV_W'(mag);
      rem <= '0;
      den <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  // quotient held in dvd once done; restore the sign
  assign q_mag    = dvd[QUO_W-1:0];
  assign quotient = neg ? $signed(~q_mag + 1'b1) : $signed(q_mag);

endmodule

// ===== src/moving_average_window_top.sv =====
// One item at a time: in_stall stays high while an item is being processed,
//   until its result is loaded. The divider resolves 4 quotient bits per cycle
//   over the 32-bit running sum.
// Steps: ring read on acceptance, then sum update, ring write and divider start.
// Reset (synchronous, rst high): window size 16, sum, position and full
//   flag cleared; ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// moving_average_window_top
// Running-sum moving average over a ring of the last window_size samples.
// ----------------------------------------------------------------------------
module moving_average_window_top #(
  parameter int WINDOW_MAX   = 256,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [mavg_pkg::CFG_W-1:0]     cfg_wr_data,
  // sample input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] average,
  output logic                           window_full
);
  import mavg_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + ADDR_W;

  mavg_state_t state, state_next;

  logic [CFG_W-1:0]              window_size;
  logic signed [SUM_W-1:0]       running_sum;
  logic [ADDR_W-1:0]             write_position;
  logic                          filled;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  logic [SIZE_W-1:0]             eff_size;
  logic [ADDR_W-1:0]             cur_pos;
  logic [ADDR_W:0]               pos_inc;
  logic                          wrap;
  logic [ADDR_W-1:0]             pos_next;
  logic                          filled_next;
  logic [SIZE_W-1:0]             count;
  logic signed [SAMPLE_WIDTH-1:0] old_val;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SAMPLE_WIDTH-1:0]       rd_data;

  logic in_accept;
  logic rd_en;
  logic wr_en;
  logic div_start;
  logic div_done;
  logic load_out;
  logic signed [SAMPLE_WIDTH-1:0] quotient;

  // effective window: zero means one, clamp to the ring depth
  always_comb begin
    if (window_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      eff_size = SIZE_W'(WINDOW_MAX);
    end else begin
      eff_size = SIZE_W'(window_size);
    end
  end

  // slot for the incoming item
  assign cur_pos = (32'(write_position) >= 32'(eff_size)) ? '0 : write_position;

  // position advance and full-window detection
  assign pos_inc     = {1'b0, write_position} + 1'b1;
  assign wrap        = (32'(pos_inc) >= 32'(eff_size));
  assign pos_next    = wrap ? '0 : pos_inc[ADDR_W-1:0];
  assign filled_next = filled | wrap;
  assign count       = filled_next ? eff_size : SIZE_W'(pos_next);

  // replaced entry counts as zero until the window has filled
  assign old_val  = filled ? $signed(rd_data) : '0;
  assign sum_next = running_sum
                  - {{(SUM_W-SAMPLE_WIDTH){old_val[SAMPLE_WIDTH-1]}}, old_val}
                  + {{(SUM_W-SAMPLE_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q};

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en      = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        wr_en      = 1'b1;
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done && (!out_valid || !out_stall)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // filter state; a config write restarts the filter
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= CFG_RESET;
      running_sum    <= '0;
      write_position <= '0;
      filled         <= 1'b0;
    end else if (cfg_wr_en) begin
      window_size    <= cfg_wr_data;
      running_sum    <= '0;
      write_position <= '0;
      filled         <= 1'b0;
    end else if (in_accept) begin
      write_position <= cur_pos;
    end else if (wr_en) begin
      running_sum    <= sum_next;
      write_position <= pos_next;
      filled         <= filled_next;
    end
  end

  // captured sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average     <= quotient;
      window_full <= filled;
    end
  end

  // sample ring
  mavg_ring #(
    .DEPTH  (WINDOW_MAX),
    .WIDTH  (SAMPLE_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (cur_pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (write_position),
    .wr_data (sample_q)
  );

  // sum / count
  mavg_div #(
    .SUM_W (SUM_W),
    .DEN_W (SIZE_W),
    .QUO_W (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== bench/tb_moving_average_window_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_window_top
// Self-checking bench for the running-sum moving average. A short table of
// items and window writes comes first, then random phases over many window
// sizes. Each result is checked in order against its typed value or an
// in-bench model of the ring, running sum and full flag. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_moving_average_window_top;
  import mavg_pkg::*;

  localparam int SW            = 24;
  localparam int WIN_MAX       = 256;
  localparam int SETTLE_CYCLES = 12;    // wait after the last result drains
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int HOLD_AFTER    = 80;    // results seen before the long hold
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_SIZE   = -1;
  localparam int NUM_PLAN      = 28;
  localparam int NUM_PHASES    = 12;

  localparam logic signed [SW-1:0] S_MAX = 2**(SW-1) - 1;
  localparam logic signed [SW-1:0] S_MIN = -(2**(SW-1));

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} plan_kind_t;
  typedef enum logic [1:0] {LEAN_NONE, LEAN_MIN, LEAN_MAX} sample_lean_t;

  typedef struct {
    plan_kind_t kind;
    int         value;
    bit         typed;
    int         want_avg;
    bit         want_full;
  } plan_row_t;

  typedef struct {
    logic signed [SW-1:0] avg;
    logic                 full;
  } avg_result_t;

  // Directed table: window writes interleaved with items; expectations typed
  // in only where obvious, the rest come from the model below.
  plan_row_t plan [NUM_PLAN] = '{
    '{ROW_SAMPLE,  8388607, 1,  8388607, 0},  // first item after reset
    '{ROW_SAMPLE, -8388608, 1,        0, 0},  // -1 / 2 truncates to zero
    '{ROW_SAMPLE,        0, 0,        0, 0},
    '{ROW_SAMPLE,        1, 0,        0, 0},
    '{ROW_CONFIG,        1, 0,        0, 0},
    '{ROW_SAMPLE, -8388608, 1, -8388608, 1},
    '{ROW_SAMPLE,  8388607, 1,  8388607, 1},
    '{ROW_CONFIG,        0, 0,        0, 0},  // zero acts as one
    '{ROW_SAMPLE,       -5, 1,       -5, 1},
    '{ROW_CONFIG,        2, 0,        0, 0},
    '{ROW_SAMPLE,       -3, 1,       -3, 0},
    '{ROW_SAMPLE,        0, 1,       -1, 1},  // -3 / 2 toward zero
    '{ROW_SAMPLE,  8388607, 0,        0, 0},
    '{ROW_SAMPLE,  8388607, 1,  8388607, 1},
    '{ROW_CONFIG,        2, 0,        0, 0},  // same value still restarts
    '{ROW_SAMPLE,        7, 1,        7, 0},
    '{ROW_CONFIG,      511, 0,        0, 0},  // saturates to WIN_MAX
    '{ROW_SAMPLE, -8388608, 1, -8388608, 0},
    '{ROW_SAMPLE,       -1, 0,        0, 0},
    '{ROW_SAMPLE,  8388607, 0,        0, 0},
    '{ROW_CONFIG,      257, 0,        0, 0},
    '{ROW_SAMPLE,      100, 1,      100, 0},
    '{ROW_SAMPLE,     -100, 0,        0, 0},
    '{ROW_CONFIG,        3, 0,        0, 0},
    '{ROW_SAMPLE, -8388608, 0,        0, 0},
    '{ROW_SAMPLE, -8388608, 0,        0, 0},
    '{ROW_SAMPLE, -8388608, 1, -8388608, 1},
    '{ROW_SAMPLE, -8388608, 1, -8388608, 1}   // first overwrite of the ring
  };

  // Random phases: window size (or random) and number of items
  int phase_size [NUM_PHASES] = '{7, 256, 1, 0, 2, 511, 13, 100,
                                  RANDOM_SIZE, RANDOM_SIZE, RANDOM_SIZE, 16};
  int phase_len  [NUM_PHASES] = '{40, 300, 30, 20, 40, 60, 60, 220, 80, 80, 80, 40};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] sample;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SW-1:0] average;
  logic                 window_full;

  // Filter model state
  logic [CFG_W-1:0]     win_reg;
  logic signed [SW-1:0] ring [WIN_MAX];
  longint               sum_acc;
  int unsigned          ring_pos;
  bit                   window_filled;

  avg_result_t expected_results [$];
  int  mismatches   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  windows_used = 0;
  int  quiet_cycles = 0;
  bit  quiet_end    = 1'b0;

  moving_average_window_top #(
    .WINDOW_MAX   (WIN_MAX),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .window_full (window_full)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clear sum, position and full flag; ring contents stay
  function automatic void restart_window();
    sum_acc       = 0;
    ring_pos      = 0;
    window_filled = 1'b0;
  endfunction

  // One item through the model: replace oldest entry, update sum, divide
  function automatic avg_result_t predict_average(input logic signed [SW-1:0] s);
    int unsigned span;
    longint      count;
    avg_result_t r;
    span = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
    if (ring_pos >= span) ring_pos = 0;
    if (window_filled) sum_acc = sum_acc - ring[ring_pos];
    sum_acc = sum_acc + s;
    ring[ring_pos] = s;
    ring_pos++;
    if (ring_pos >= span) begin
      ring_pos      = 0;
      window_filled = 1'b1;
    end
    count  = window_filled ? longint'(span) : longint'(ring_pos);
    r.avg  = SW'(sum_acc / count);  // SV division truncates toward zero
    r.full = window_filled;
    return r;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample(input sample_lean_t lean);
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    case (lean)
      LEAN_MIN: if ($urandom_range(0, 31) != 0) v = S_MIN;
      LEAN_MAX: if ($urandom_range(0, 31) != 0) v = S_MAX;
      default: begin
        case ($urandom_range(0, 9))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = '0;
          3: v = SW'(int'($urandom_range(0, 16)) - 8);
          default: ;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Offer one item and hold it until accepted, then queue its expectation
  task automatic push_sample(input logic signed [SW-1:0] s, input bit typed,
                             input avg_result_t typed_want);
    avg_result_t want;
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_average(s);
    expected_results.push_back(typed ? typed_want : want);
    items_sent++;
  endtask

  // Random sender gap after an accepted item
  task automatic sender_pause();
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Window write only once the block has drained
  task automatic write_window(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_reg = v;
    restart_window();
    windows_used++;
  endtask

  // Stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    avg_result_t  typed_want;
    sample_lean_t lean;
    int           size;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    sample      <= '0;
    win_reg = CFG_RESET;
    restart_window();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        write_window(CFG_W'(plan[i].value));
      end else begin
        typed_want.avg  = SW'(plan[i].want_avg);
        typed_want.full = plan[i].want_full;
        push_sample(SW'(plan[i].value), plan[i].typed, typed_want);
        sender_pause();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      size = (phase_size[p] == RANDOM_SIZE) ? $urandom_range(1, 64) : phase_size[p];
      if (p == NUM_PHASES - 1) quiet_end = 1'b1;
      write_window(CFG_W'(size));
      for (int k = 0; k < phase_len[p]; k++) begin
        // full-size window: long run near the minimum, then near the maximum
        if (size == WIN_MAX) lean = (k < 280) ? LEAN_MIN : LEAN_MAX;
        else lean = LEAN_NONE;
        push_sample(pick_sample(lean), 1'b0, typed_want);
        sender_pause();
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Checked %0d averages from %0d items over %0d window writes,",
             results_seen, items_sent, windows_used);
    $display("covering sizes 0, 1, 2, 256 and saturated, with both sides stalling.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold to back up the block
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && !hold_done && results_seen >= HOLD_AFTER) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end else if (stall_left == 0 && !quiet_end && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    avg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result (average)", 0, average);
      end else begin
        want = expected_results.pop_front();
        if (average !== want.avg) flag_mismatch("average", want.avg, average);
        if (window_full !== want.full) flag_mismatch("window_full", want.full, window_full);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
src/mavg_pkg.sv
src/mavg_ring.sv
src/mavg_div.sv
src/moving_average_window_top.sv
bench/tb_moving_average_window_top.sv
